FILE: hw/rtl/cbi_pkg.sv
// Package for the convolutional byte interleaver: sizes, types, source codes
// and the branch address helpers. No dependencies.
package cbi_pkg;

    localparam int BRANCHES    = 12;
    localparam int UNIT_DELAY  = 17;
    localparam int STORE_DEPTH = UNIT_DELAY * BRANCHES * (BRANCHES - 1) / 2;

    localparam int BR_W   = $clog2(BRANCHES);
    localparam int PTR_W  = $clog2(UNIT_DELAY * (BRANCHES - 1) + 1);
    localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int TRI_W  = 2 * BR_W;
    localparam int SRC_W  = 2;

    typedef logic [7:0]        t_byte;
    typedef logic [BR_W-1:0]   t_branch;
    typedef logic [PTR_W-1:0]  t_ptr;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [SRC_W-1:0]  t_src;

    localparam t_src SRC_BYTE = 2'd0;
    localparam t_src SRC_ZERO = 2'd1;
    localparam t_src SRC_MEM  = 2'd2;

    typedef struct packed {
        t_addr addr;
        t_byte data;
        logic  wr;
        t_src  src;
    } t_cmd;

    function automatic t_addr f_base(input t_branch j);
        logic [TRI_W-1:0] jj;
        logic [TRI_W-1:0] tri_num;
        jj      = TRI_W'(j);
        tri_num = (jj * (jj - TRI_W'(1))) >> 1;
        return ADDR_W'(ADDR_W'(UNIT_DELAY) * ADDR_W'(tri_num));
    endfunction

    function automatic t_ptr f_last(input t_branch j);
        t_ptr len;
        len = PTR_W'(PTR_W'(UNIT_DELAY) * PTR_W'(j));
        return len - PTR_W'(1);
    endfunction

endpackage

FILE: hw/rtl/cbi_in_if.sv
// Input byte channel of the interleaver: valid, ready and data_byte.
// Depends on cbi_pkg.
interface cbi_in_if;
    logic           valid;
    logic           ready;
    cbi_pkg::t_byte data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

FILE: hw/rtl/cbi_out_if.sv
// Output byte channel of the interleaver: valid, ready and data_out.
// Depends on cbi_pkg.
interface cbi_out_if;
    logic           valid;
    logic           ready;
    cbi_pkg::t_byte data_out;

    modport source (output valid, output data_out, input ready);
    modport sink (input valid, input data_out, output ready);
endinterface

FILE: hw/rtl/cbi_front.sv
// Front end: accepts input bytes, tracks branch counter, branch pointers and
// fill flags, and emits one store command per byte. Depends on cbi_pkg, cbi_in_if.
module cbi_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cbi_in_if.sink        i_in,
    input  logic          i_q_ready,
    output logic          o_push,
    output cbi_pkg::t_cmd o_cmd
);
    import cbi_pkg::*;

    t_branch             r_branch;
    t_branch             n_branch;
    t_ptr                r_ptr [BRANCHES];
    logic [BRANCHES-1:0] r_filled;
    t_ptr                cur_ptr;
    t_ptr                n_ptr;
    logic                wrap;
    logic                delayed;

    assign i_in.ready = i_q_ready;
    assign o_push     = i_in.valid && i_q_ready;

    always_comb begin
        cur_ptr = r_ptr[r_branch];
        delayed = (r_branch != '0);
        wrap    = (cur_ptr == f_last(r_branch));
        n_ptr   = wrap ? '0 : cur_ptr + PTR_W'(1);
        n_branch = (r_branch == BR_W'(BRANCHES - 1)) ? '0 : r_branch + BR_W'(1);

        o_cmd.addr = f_base(r_branch) + ADDR_W'(cur_ptr);
        o_cmd.data = i_in.data_byte;
        o_cmd.wr   = delayed;
        if (!delayed) begin
            o_cmd.src = SRC_BYTE;
        end else if (r_filled[r_branch]) begin
            o_cmd.src = SRC_MEM;
        end else begin
            o_cmd.src = SRC_ZERO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_branch <= '0;
            r_filled <= '0;
            for (int k = 0; k < BRANCHES; k++) begin
                r_ptr[k] <= '0;
            end
        end else if (o_push) begin
            r_branch <= n_branch;
            if (delayed) begin
                r_ptr[r_branch] <= n_ptr;
                if (wrap) begin
                    r_filled[r_branch] <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: hw/rtl/cbi_queue.sv
// Two-entry command queue between front and back end.
// Depends on cbi_pkg.
module cbi_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cbi_pkg::t_cmd i_cmd,
    output logic          o_ready,
    input  logic          i_pop,
    output logic          o_valid,
    output cbi_pkg::t_cmd o_cmd
);
    import cbi_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_slot[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

FILE: hw/rtl/cbi_back.sv
// Back end: runs store commands against the delay memory and holds the result
// byte until taken. Depends on cbi_pkg, cbi_out_if.
module cbi_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  cbi_pkg::t_cmd i_cmd,
    output logic          o_pop,
    cbi_out_if.source     o_out
);
    import cbi_pkg::*;

    t_byte r_mem [STORE_DEPTH];
    t_byte r_rd_data;
    t_byte r_data;
    t_src  r_src;
    logic  r_valid;
    logic  n_valid;

    assign o_pop = i_valid && (!r_valid || o_out.ready);

    always_comb begin
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // read old byte, write new byte at the same address
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd_data <= r_mem[i_cmd.addr];
            r_data    <= i_cmd.data;
            r_src     <= i_cmd.src;
            if (i_cmd.wr) begin
                r_mem[i_cmd.addr] <= i_cmd.data;
            end
        end
    end

    assign o_out.valid = r_valid;

    always_comb begin
        unique case (r_src)
            SRC_BYTE: o_out.data_out = r_data;
            SRC_ZERO: o_out.data_out = '0;
            SRC_MEM:  o_out.data_out = r_rd_data;
            default:  o_out.data_out = '0;
        endcase
    end

endmodule

FILE: hw/rtl/convolutional_byte_interleaver.sv
// Top level of the convolutional byte interleaver: front end, command queue,
// back end with delay memory. Depends on cbi_pkg, cbi_in_if, cbi_out_if.
//
//   Channel  Dir  Payload         Meaning
//   i_in     in   data_byte[7:0]  next byte of the stream
//   o_out    out  data_out[7:0]   byte leaving the current branch
//
// One byte per cycle sustained while o_out is ready. A byte accepted on i_in
// is registered into the queue, then the registered read of the single delay
// memory in the back end offers it on o_out.
// Reset is synchronous; no clearing pass: per-branch fill flags make a branch
// read zeros until its pointer first wraps.
// A stalled o_out fills the two-entry queue, then i_in.ready drops.
module convolutional_byte_interleaver (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cbi_in_if.sink    i_in,
    cbi_out_if.source o_out
);
    import cbi_pkg::*;

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic push;
    logic pop;
    logic q_ready;
    logic q_valid;

    cbi_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_cmd     (front_cmd)
    );

    cbi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (queue_cmd)
    );

    cbi_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (queue_cmd),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
